// File: sv/mfdd_pkg.sv
// ----------------------------------------------------------------------------
// mfdd_pkg
// Shared codes, reset values and types of the motion fault debounce detector.
// ----------------------------------------------------------------------------
package mfdd_pkg;

  // health codes
  localparam logic [1:0] HEALTH_OK     = 2'd0;
  localparam logic [1:0] HEALTH_WARN   = 2'd1;
  localparam logic [1:0] HEALTH_EMERG  = 2'd2;

  // fault codes
  localparam logic [1:0] FAULT_CLEAR     = 2'd0;
  localparam logic [1:0] FAULT_FREE_FALL = 2'd1;
  localparam logic [1:0] FAULT_ESTOP     = 2'd2;
  localparam logic [1:0] FAULT_VIBRATION = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_FF_THR   = 3'd0;
  localparam logic [2:0] REG_IMP_THR  = 3'd1;
  localparam logic [2:0] REG_VIB_HIGH = 3'd2;
  localparam logic [2:0] REG_VIB_MED  = 3'd3;
  localparam logic [2:0] REG_Z_OFF    = 3'd4;
  localparam logic [2:0] REG_GOFF_X   = 3'd5;
  localparam logic [2:0] REG_GOFF_Y   = 3'd6;
  localparam logic [2:0] REG_GOFF_Z   = 3'd7;

  // configuration reset values
  localparam logic [15:0] FF_THR_RST   = 16'd1433;
  localparam logic [15:0] IMP_THR_RST  = 16'd1228;
  localparam logic [14:0] VIB_HIGH_RST = 15'd100;
  localparam logic [14:0] VIB_MED_RST  = 15'd50;

  // saturation limits of a 16 bit signed value
  localparam logic [15:0] SAT_POS = 16'h7FFF;
  localparam logic [15:0] SAT_NEG = 16'h8000;

  // thresholds seen by the classifier
  typedef struct packed {
    logic [15:0] ff;
    logic [15:0] imp;
    logic [15:0] hi;
    logic [15:0] med;
  } thr_t;

  // instant class of one sample
  typedef struct packed {
    logic [1:0]  health;
    logic [1:0]  fault;
    logic [15:0] value;
  } class_t;

endpackage

// File: sv/mfdd_accum.sv
// ----------------------------------------------------------------------------
// mfdd_accum
// Axis-serial accumulator: one axis per cycle through shift lines, summing
// the accel squares and the absolute gyro deviations.
// ----------------------------------------------------------------------------
module mfdd_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_x_i,
  input  logic signed [15:0] gyro_y_i,
  input  logic signed [15:0] gyro_z_i,
  input  logic signed [15:0] goff_x_i,
  input  logic signed [15:0] goff_y_i,
  input  logic signed [15:0] goff_z_i,
  input  logic signed [15:0] z_off_i,
  output logic               done_o,
  output logic [31:0]        sq_sum_o,
  output logic [17:0]        vib_sum_o,
  output logic signed [16:0] dz_o
);

  logic signed [15:0] acc_sh_q [3];
  logic signed [15:0] gyr_sh_q [3];
  logic signed [15:0] off_sh_q [3];
  logic [31:0]        sq_q;
  logic [17:0]        vib_q;
  logic signed [16:0] dz_q;
  logic [1:0]         step_q;
  logic               run_q;
  logic               done_q;

  logic signed [31:0] sq_term;
  logic signed [16:0] gdiff;
  logic [16:0]        gabs;

  assign sq_term = acc_sh_q[0] * acc_sh_q[0];
  assign gdiff   = {gyr_sh_q[0][15], gyr_sh_q[0]} - {off_sh_q[0][15], off_sh_q[0]};
  assign gabs    = gdiff[16] ? 17'(-gdiff) : 17'(gdiff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd2) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_sh_q <= '{accel_x_i, accel_y_i, accel_z_i};
      gyr_sh_q <= '{gyro_x_i, gyro_y_i, gyro_z_i};
      off_sh_q <= '{goff_x_i, goff_y_i, goff_z_i};
      sq_q     <= '0;
      vib_q    <= '0;
      dz_q     <= {accel_z_i[15], accel_z_i} - {z_off_i[15], z_off_i};
    end else if (run_q) begin
      // accumulate the head axis, then advance the shift lines
      sq_q        <= sq_q + unsigned'(sq_term);
      vib_q       <= vib_q + 18'(gabs);
      acc_sh_q[0] <= acc_sh_q[1];
      acc_sh_q[1] <= acc_sh_q[2];
      gyr_sh_q[0] <= gyr_sh_q[1];
      gyr_sh_q[1] <= gyr_sh_q[2];
      off_sh_q[0] <= off_sh_q[1];
      off_sh_q[1] <= off_sh_q[2];
    end
  end

  assign done_o    = done_q;
  assign sq_sum_o  = sq_q;
  assign vib_sum_o = vib_q;
  assign dz_o      = dz_q;

endmodule

// File: sv/mfdd_isqrt.sv
// ----------------------------------------------------------------------------
// mfdd_isqrt
// Digit-serial floor square root: two radicand bits enter per cycle,
// one root bit leaves per cycle.
// ----------------------------------------------------------------------------
module mfdd_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] rad_i,
  output logic        done_o,
  output logic [15:0] root_o
);

  logic [31:0] rad_sh_q;
  logic [16:0] rem_q;
  logic [15:0] root_q;
  logic [3:0]  iter_q;
  logic        run_q;
  logic        done_q;

  logic [18:0] cur;
  logic [18:0] trial;
  logic        fits;

  assign cur   = {rem_q, rad_sh_q[31:30]};
  assign trial = {1'b0, root_q, 2'b01};
  assign fits  = cur >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        iter_q <= '0;
      end else if (run_q) begin
        iter_q <= iter_q + 4'd1;
        if (iter_q == 4'd15) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_sh_q <= rad_i;
      rem_q    <= '0;
      root_q   <= '0;
    end else if (run_q) begin
      rad_sh_q <= {rad_sh_q[29:0], 2'b00};
      if (fits) begin
        rem_q  <= 17'(cur - trial);
        root_q <= {root_q[14:0], 1'b1};
      end else begin
        rem_q  <= cur[16:0];
        root_q <= {root_q[14:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: sv/mfdd_classify.sv
// ----------------------------------------------------------------------------
// mfdd_classify
// Instant class of one sample in priority order: free fall, impact,
// emergency shake, warning shake, stable.
// ----------------------------------------------------------------------------
module mfdd_classify (
  input  logic [15:0]         mag_i,
  input  logic signed [16:0]  dz_i,
  input  logic [17:0]         vib_i,
  input  mfdd_pkg::thr_t      thr_i,
  output mfdd_pkg::class_t    cls_o
);

  logic [16:0] dz_abs;
  logic [16:0] vib_half;
  logic [15:0] mag_sat;
  logic [15:0] dz_sat;
  logic [15:0] vib_sat;

  assign dz_abs   = dz_i[16] ? 17'(-dz_i) : 17'(dz_i);
  assign vib_half = vib_i[17:1];
  assign mag_sat  = mag_i[15] ? mfdd_pkg::SAT_POS : mag_i;
  assign vib_sat  = (|vib_half[16:15]) ? mfdd_pkg::SAT_POS : vib_half[15:0];

  always_comb begin
    case (dz_i[16:15])
      2'b01:   dz_sat = mfdd_pkg::SAT_POS;
      2'b10:   dz_sat = mfdd_pkg::SAT_NEG;
      default: dz_sat = dz_i[15:0];
    endcase
  end

  always_comb begin
    cls_o.health = mfdd_pkg::HEALTH_OK;
    cls_o.fault  = mfdd_pkg::FAULT_CLEAR;
    cls_o.value  = '0;
    if (mag_i < thr_i.ff) begin
      cls_o.health = mfdd_pkg::HEALTH_EMERG;
      cls_o.fault  = mfdd_pkg::FAULT_FREE_FALL;
      cls_o.value  = mag_sat;
    end else if (dz_abs > {1'b0, thr_i.imp}) begin
      cls_o.health = mfdd_pkg::HEALTH_EMERG;
      cls_o.fault  = mfdd_pkg::FAULT_ESTOP;
      cls_o.value  = dz_sat;
    end else if (vib_i > {2'b00, thr_i.hi}) begin
      cls_o.health = mfdd_pkg::HEALTH_EMERG;
      cls_o.fault  = mfdd_pkg::FAULT_VIBRATION;
      cls_o.value  = vib_sat;
    end else if (vib_i > {2'b00, thr_i.med}) begin
      cls_o.health = mfdd_pkg::HEALTH_WARN;
      cls_o.fault  = mfdd_pkg::FAULT_VIBRATION;
      cls_o.value  = vib_sat;
    end
  end

endmodule

// File: sv/motion_fault_debounce_detector.sv
// ----------------------------------------------------------------------------
// motion_fault_debounce_detector
// Six-axis motion fault classifier with an up/down debounce counter.
// ----------------------------------------------------------------------------
// Each input beat is one raw accel/gyro sample; each produces exactly one
// result beat carrying the held health, held fault, held fault value and the
// debounce counter after that sample. A sample runs through the axis-serial
// accumulation (one axis a cycle through shift lines), the digit-serial
// square root of the accel sum of squares (one root bit a cycle), and
// hand-off and commit, the square root being the longest step; no new
// sample is accepted before it commits. The next sample is accepted while a
// result still waits on the output; its commit then holds until the
// waiting beat is taken. Write configuration only while no sample is in
// flight; a write that lands mid-sample is not held off.
module motion_fault_debounce_detector #(
  parameter int DEBOUNCE_LIMIT = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_wdata_i,
  // sample channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] accel_x_sample_i,
  input  logic signed [15:0] accel_y_sample_i,
  input  logic signed [15:0] accel_z_sample_i,
  input  logic signed [15:0] gyro_x_sample_i,
  input  logic signed [15:0] gyro_y_sample_i,
  input  logic signed [15:0] gyro_z_sample_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         health_level_o,
  output logic [1:0]         fault_kind_o,
  output logic signed [15:0] fault_value_o,
  output logic [3:0]         debounce_level_o
);

  // counter wide enough for the limit, and at least as wide as the output
  localparam int CW_MIN = $clog2(DEBOUNCE_LIMIT + 1);
  localparam int CW     = (CW_MIN > 4) ? CW_MIN : 4;
  localparam logic [CW-1:0] LIMIT = CW'(DEBOUNCE_LIMIT);

  // 1/5 as a fixed-point reciprocal, exact over the 18 bit range of 7*base
  localparam logic [19:0] RECIP5 = 20'd838861;

  // sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  // configuration registers
  logic [15:0]        ff_thr_q, imp_thr_q;
  logic [14:0]        vib_high_q, vib_med_q;
  logic signed [15:0] z_off_q, goff_x_q, goff_y_q, goff_z_q;

  // held state
  logic [1:0]    held_health_q, held_health_d;
  logic [1:0]    held_fault_q, held_fault_d;
  logic [15:0]   held_value_q, held_value_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q;

  // shake thresholds, scaled one per cycle while the axes accumulate
  logic        scl_idx_q;
  logic [15:0] hi_thr_q, med_thr_q;
  logic [15:0] scaled;

  logic               in_beat, commit;
  logic               acc_done, root_done;
  logic [31:0]        sq_sum;
  logic [17:0]        vib_sum;
  logic signed [16:0] dz;
  logic [15:0]        mag;
  mfdd_pkg::thr_t     thr;
  mfdd_pkg::class_t   cls;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  // commit only when the output slot is free or being emptied
  assign commit     = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_thr_q   <= mfdd_pkg::FF_THR_RST;
      imp_thr_q  <= mfdd_pkg::IMP_THR_RST;
      vib_high_q <= mfdd_pkg::VIB_HIGH_RST;
      vib_med_q  <= mfdd_pkg::VIB_MED_RST;
      z_off_q    <= '0;
      goff_x_q   <= '0;
      goff_y_q   <= '0;
      goff_z_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mfdd_pkg::REG_FF_THR:   ff_thr_q   <= cfg_wdata_i;
        mfdd_pkg::REG_IMP_THR:  imp_thr_q  <= cfg_wdata_i;
        mfdd_pkg::REG_VIB_HIGH: vib_high_q <= cfg_wdata_i[14:0];
        mfdd_pkg::REG_VIB_MED:  vib_med_q  <= cfg_wdata_i[14:0];
        mfdd_pkg::REG_Z_OFF:    z_off_q    <= cfg_wdata_i;
        mfdd_pkg::REG_GOFF_X:   goff_x_q   <= cfg_wdata_i;
        mfdd_pkg::REG_GOFF_Y:   goff_y_q   <= cfg_wdata_i;
        mfdd_pkg::REG_GOFF_Z:   goff_z_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------ threshold scaler
  // Double the base; while a fault is held, cut to 7/10 of that, which is
  // floor(7 * base / 5).
  function automatic logic [15:0] scale_thr(input logic [14:0] base, input logic held);
    logic [17:0] x7;
    logic [37:0] prod;
    x7   = {base, 3'b000} - {3'b000, base};
    prod = {20'd0, x7} * {18'd0, RECIP5};
    return held ? prod[37:22] : {base, 1'b0};
  endfunction

  assign scaled = scale_thr(scl_idx_q ? vib_med_q : vib_high_q,
                            held_health_q != mfdd_pkg::HEALTH_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scl_idx_q <= 1'b0;
    end else if (in_beat) begin
      scl_idx_q <= 1'b0;
    end else if (state_q == ST_ACC) begin
      scl_idx_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACC) begin
      if (scl_idx_q) begin
        med_thr_q <= scaled;
      end else begin
        hi_thr_q <= scaled;
      end
    end
  end

  // ------------------------------------------------------------- datapath
  mfdd_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_beat),
    .accel_x_i (accel_x_sample_i),
    .accel_y_i (accel_y_sample_i),
    .accel_z_i (accel_z_sample_i),
    .gyro_x_i  (gyro_x_sample_i),
    .gyro_y_i  (gyro_y_sample_i),
    .gyro_z_i  (gyro_z_sample_i),
    .goff_x_i  (goff_x_q),
    .goff_y_i  (goff_y_q),
    .goff_z_i  (goff_z_q),
    .z_off_i   (z_off_q),
    .done_o    (acc_done),
    .sq_sum_o  (sq_sum),
    .vib_sum_o (vib_sum),
    .dz_o      (dz)
  );

  mfdd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_done && (state_q == ST_ACC)),
    .rad_i   (sq_sum),
    .done_o  (root_done),
    .root_o  (mag)
  );

  assign thr.ff  = ff_thr_q;
  assign thr.imp = imp_thr_q;
  assign thr.hi  = hi_thr_q;
  assign thr.med = med_thr_q;

  mfdd_classify u_classify (
    .mag_i (mag),
    .dz_i  (dz),
    .vib_i (vib_sum),
    .thr_i (thr),
    .cls_o (cls)
  );

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_beat)   state_d = ST_ACC;
      ST_ACC:  if (acc_done)  state_d = ST_ROOT;
      ST_ROOT: if (root_done) state_d = ST_DONE;
      ST_DONE: if (commit)    state_d = ST_IDLE;
      default:                state_d = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------- debounce
  // Rise on a non-stable sample up to the limit and latch there; fall on a
  // stable one and clear everything held on reaching zero.
  always_comb begin
    cnt_d         = cnt_q;
    held_health_d = held_health_q;
    held_fault_d  = held_fault_q;
    held_value_d  = held_value_q;
    if (cls.health != mfdd_pkg::HEALTH_OK) begin
      if (cnt_q < LIMIT) cnt_d = cnt_q + CW'(1);
      if (cnt_d >= LIMIT) begin
        held_health_d = cls.health;
        held_fault_d  = cls.fault;
        held_value_d  = cls.value;
      end
    end else begin
      if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
      if (cnt_d == '0) begin
        held_health_d = mfdd_pkg::HEALTH_OK;
        held_fault_d  = mfdd_pkg::FAULT_CLEAR;
        held_value_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      cnt_q         <= '0;
      held_health_q <= mfdd_pkg::HEALTH_OK;
      held_fault_q  <= mfdd_pkg::FAULT_CLEAR;
      held_value_q  <= '0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q   <= 1'b1;
        cnt_q         <= cnt_d;
        held_health_q <= held_health_d;
        held_fault_q  <= held_fault_d;
        held_value_q  <= held_value_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // the held state only moves at commit, so it doubles as the output beat
  assign out_valid_o      = out_valid_q;
  assign health_level_o   = held_health_q;
  assign fault_kind_o     = held_fault_q;
  assign fault_value_o    = held_value_q;
  assign debounce_level_o = cnt_q[3:0];

endmodule

// File: tb/sv/motion_fault_debounce_detector_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motion_fault_debounce_detector_test
// Self-checking bench for the six-axis motion fault debounce detector.
// ----------------------------------------------------------------------------
// Drives raw accel/gyro samples through the valid/ready sample channel. An
// independent predictor classifies each accepted beat, runs the up/down
// debounce counter and queues the held status it expects. Every result beat
// is compared against the oldest queued status. A short directed table comes
// first: threshold boundaries, field extremes, latching at the counter limit,
// the reduced shake thresholds while a fault is held, and the clear at zero.
// Random phases follow, each under its own register settings (minimum,
// maximum, reset values, random), with sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module motion_fault_debounce_detector_test;

  localparam int DEBOUNCE_LIMIT  = 10;
  localparam int SAMPLE_CYCLES   = 23;    // accept-to-accept time of one sample
  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int QUIET_LIMIT     = 4000;  // cycles without any beat moving
  localparam int REPORT_LIMIT    = 10;

  // one raw sample, fields as they appear on the ports
  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] gz;
  } sample_t;

  // one result beat: held health, held fault, held value, debounce counter
  typedef struct packed {
    logic [1:0]  health;
    logic [1:0]  fault;
    logic [15:0] value;
    logic [3:0]  level;
  } status_t;

  // directed stimulus row; typed rows carry a hand-written expectation
  typedef struct packed {
    sample_t s;
    bit      typed;
    status_t want;
  } row_t;

  // shape of a random sample relative to the current settings
  typedef enum int {
    KIND_STABLE,
    KIND_FREE_FALL,
    KIND_IMPACT,
    KIND_SHAKE,
    KIND_NOISE
  } kind_e;

  // --------------------------------------------------------------------------
  // DUT ports
  // --------------------------------------------------------------------------
  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               cfg_we_i         = 1'b0;
  logic [2:0]         cfg_index_i      = mfdd_pkg::REG_FF_THR;
  logic [15:0]        cfg_wdata_i      = '0;
  logic               in_valid_i       = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] accel_x_sample_i = '0;
  logic signed [15:0] accel_y_sample_i = '0;
  logic signed [15:0] accel_z_sample_i = '0;
  logic signed [15:0] gyro_x_sample_i  = '0;
  logic signed [15:0] gyro_y_sample_i  = '0;
  logic signed [15:0] gyro_z_sample_i  = '0;
  logic               out_valid_o;
  logic               out_ready_i      = 1'b0;
  logic [1:0]         health_level_o;
  logic [1:0]         fault_kind_o;
  logic signed [15:0] fault_value_o;
  logic [3:0]         debounce_level_o;

  motion_fault_debounce_detector #(
    .DEBOUNCE_LIMIT(DEBOUNCE_LIMIT)
  ) dut (.*);

  // --------------------------------------------------------------------------
  // Predictor copy of the settings and of the held state, at reset values
  // --------------------------------------------------------------------------
  logic [15:0]        cfg_ff_thr   = mfdd_pkg::FF_THR_RST;
  logic [15:0]        cfg_imp_thr  = mfdd_pkg::IMP_THR_RST;
  logic [14:0]        cfg_vib_high = mfdd_pkg::VIB_HIGH_RST;
  logic [14:0]        cfg_vib_med  = mfdd_pkg::VIB_MED_RST;
  logic signed [15:0] cfg_z_off    = '0;
  logic signed [15:0] cfg_goff_x   = '0;
  logic signed [15:0] cfg_goff_y   = '0;
  logic signed [15:0] cfg_goff_z   = '0;

  logic [1:0]  held_health    = mfdd_pkg::HEALTH_OK;
  logic [1:0]  held_fault     = mfdd_pkg::FAULT_CLEAR;
  logic [15:0] held_value     = '0;
  int          debounce_count = 0;

  status_t held_status_q [$];   // predicted result beats, oldest first
  int      mismatches   = 0;
  int      quiet_cycles = 0;

  // expectation handed over from the directed table along with the beat
  bit      row_typed = 1'b0;
  status_t row_want  = '0;

  // receiver stall pattern
  logic [7:0] stall_mask = 8'hFF;
  int         rcv_tick   = 0;

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  // Rows 2..11 are all non-stable, so row 11 drives the counter to the limit
  // and latches. Rows 12..15 stay at the limit and re-latch each class; rows
  // 14 and 15 exercise the shake thresholds cut to 7/10 while a fault is held.
  // Ten stable rows then walk the counter back down and clear the held fields.
  row_t directed_rows [25] = '{
    // magnitude exactly at the free fall threshold: stable after reset
    '{'{16'd1433, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{mfdd_pkg::HEALTH_OK, mfdd_pkg::FAULT_CLEAR, 16'd0, 4'd0}},
    // zero vector: free fall, counter rises, nothing latched yet
    '{'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{mfdd_pkg::HEALTH_OK, mfdd_pkg::FAULT_CLEAR, 16'd0, 4'd1}},
    '{'{mfdd_pkg::SAT_NEG, mfdd_pkg::SAT_NEG, mfdd_pkg::SAT_NEG,
        mfdd_pkg::SAT_NEG, mfdd_pkg::SAT_NEG, mfdd_pkg::SAT_NEG}, 1'b0, '0},
    '{'{16'd0, 16'd0, mfdd_pkg::SAT_POS, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{16'd1433, 16'd0, 16'd0,
        mfdd_pkg::SAT_POS, mfdd_pkg::SAT_POS, mfdd_pkg::SAT_POS}, 1'b0, '0},
    '{'{16'd1433, 16'd0, 16'd0,
        mfdd_pkg::SAT_NEG, mfdd_pkg::SAT_NEG, mfdd_pkg::SAT_NEG}, 1'b0, '0},
    '{'{16'd1433, 16'd0, 16'd0, 16'd150, 16'd0, 16'd0}, 1'b0, '0},
    '{'{mfdd_pkg::SAT_POS, mfdd_pkg::SAT_POS, mfdd_pkg::SAT_POS,
        16'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{16'd0, 16'd1000, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{16'h0001, 16'hFFFF, 16'd0, 16'hFFFF, 16'h0001, 16'd0}, 1'b0, '0},
    // counter hits the limit on a free fall of magnitude 1000
    '{'{16'd600, 16'd800, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{mfdd_pkg::HEALTH_EMERG, mfdd_pkg::FAULT_FREE_FALL, 16'd1000, 4'd10}},
    // most negative z: impact, value at the negative extreme
    '{'{16'd0, 16'd0, mfdd_pkg::SAT_NEG, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{mfdd_pkg::HEALTH_EMERG, mfdd_pkg::FAULT_ESTOP, mfdd_pkg::SAT_NEG, 4'd10}},
    // full-scale shake: half the sum saturates
    '{'{16'd1433, 16'd0, 16'd0,
        mfdd_pkg::SAT_POS, mfdd_pkg::SAT_POS, mfdd_pkg::SAT_POS}, 1'b1,
      '{mfdd_pkg::HEALTH_EMERG, mfdd_pkg::FAULT_VIBRATION, mfdd_pkg::SAT_POS, 4'd10}},
    '{'{16'd1433, 16'd0, 16'd0, 16'd150, 16'd0, 16'd0}, 1'b0, '0},
    '{'{16'd1433, 16'd0, 16'd0, 16'd0, 16'd0, 16'd100}, 1'b0, '0},
    '{'{16'd1433, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{mfdd_pkg::SAT_NEG, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{16'd0, mfdd_pkg::SAT_POS, 16'd0, 16'd20, 16'hFFEC, 16'd0}, 1'b0, '0},
    // z deviation exactly at the impact threshold, both signs
    '{'{16'd1433, 16'd0, 16'd1228, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{16'd1433, 16'd0, 16'hFB34, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
    // vibration exactly at the reduced warning threshold
    '{'{16'd1433, 16'd0, 16'd0, 16'd70, 16'd0, 16'd0}, 1'b0, '0},
    '{'{16'd1433, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{16'd1433, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{16'd1433, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
    // counter back at zero: held fields clear
    '{'{16'd1433, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}, 1'b1,
      '{mfdd_pkg::HEALTH_OK, mfdd_pkg::FAULT_CLEAR, 16'd0, 4'd0}}
  };

  // --------------------------------------------------------------------------
  // Arithmetic helpers
  // --------------------------------------------------------------------------
  function automatic longint abs_l(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [15:0] clamp16(input longint v);
    if (v > 32767) return mfdd_pkg::SAT_POS;
    if (v < -32768) return mfdd_pkg::SAT_NEG;
    return 16'(v);
  endfunction

  // uniform in [-span, span]
  function automatic longint srand(input longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: classify one sample, step the debounce counter, return the
  // held status that the result beat must carry
  // --------------------------------------------------------------------------
  function automatic status_t predict_held_status(input sample_t s);
    longint     sq, root, trial, vib, dz, hi, med, val;
    logic [1:0] inst_health, inst_fault;
    int         b;
    status_t    res;
    sq = longint'($signed(s.ax)) * longint'($signed(s.ax))
       + longint'($signed(s.ay)) * longint'($signed(s.ay))
       + longint'($signed(s.az)) * longint'($signed(s.az));
    // floor square root, one result bit at a time from the top
    root = 0;
    for (b = 16; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= sq) root = trial;
    end
    vib = abs_l(longint'($signed(s.gx)) - longint'(cfg_goff_x))
        + abs_l(longint'($signed(s.gy)) - longint'(cfg_goff_y))
        + abs_l(longint'($signed(s.gz)) - longint'(cfg_goff_z));
    dz  = longint'($signed(s.az)) - longint'(cfg_z_off);
    hi  = 2 * longint'(cfg_vib_high);
    med = 2 * longint'(cfg_vib_med);
    // tighten shake thresholds while anything is held
    if (held_health != mfdd_pkg::HEALTH_OK) begin
      hi  = hi * 7 / 10;
      med = med * 7 / 10;
    end

    inst_health = mfdd_pkg::HEALTH_OK;
    inst_fault  = mfdd_pkg::FAULT_CLEAR;
    val         = 0;
    if (root < longint'(cfg_ff_thr)) begin
      inst_health = mfdd_pkg::HEALTH_EMERG;
      inst_fault  = mfdd_pkg::FAULT_FREE_FALL;
      val         = root;
    end else if (abs_l(dz) > longint'(cfg_imp_thr)) begin
      inst_health = mfdd_pkg::HEALTH_EMERG;
      inst_fault  = mfdd_pkg::FAULT_ESTOP;
      val         = dz;
    end else if (vib > hi) begin
      inst_health = mfdd_pkg::HEALTH_EMERG;
      inst_fault  = mfdd_pkg::FAULT_VIBRATION;
      val         = vib / 2;
    end else if (vib > med) begin
      inst_health = mfdd_pkg::HEALTH_WARN;
      inst_fault  = mfdd_pkg::FAULT_VIBRATION;
      val         = vib / 2;
    end

    if (inst_health != mfdd_pkg::HEALTH_OK) begin
      if (debounce_count < DEBOUNCE_LIMIT) debounce_count++;
      if (debounce_count >= DEBOUNCE_LIMIT) begin
        held_health = inst_health;
        held_fault  = inst_fault;
        held_value  = clamp16(val);
      end
    end else begin
      if (debounce_count > 0) debounce_count--;
      if (debounce_count == 0) begin
        held_health = mfdd_pkg::HEALTH_OK;
        held_fault  = mfdd_pkg::FAULT_CLEAR;
        held_value  = '0;
      end
    end

    res.health = held_health;
    res.fault  = held_fault;
    res.value  = held_value;
    res.level  = 4'(debounce_count);
    return res;
  endfunction

  // mirror a register write into the predictor
  task automatic store_setting(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      mfdd_pkg::REG_FF_THR:   cfg_ff_thr   = data;
      mfdd_pkg::REG_IMP_THR:  cfg_imp_thr  = data;
      mfdd_pkg::REG_VIB_HIGH: cfg_vib_high = data[14:0];
      mfdd_pkg::REG_VIB_MED:  cfg_vib_med  = data[14:0];
      mfdd_pkg::REG_Z_OFF:    cfg_z_off    = data;
      mfdd_pkg::REG_GOFF_X:   cfg_goff_x   = data;
      mfdd_pkg::REG_GOFF_Y:   cfg_goff_y   = data;
      mfdd_pkg::REG_GOFF_Z:   cfg_goff_z   = data;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on a rotating 8-bit mask, re-drawn from a random choice.
  // A full mask gives stretches with no stalls at all.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rcv_tick % 128 == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_mask = 8'hFF;
        1:       stall_mask = 8'h01;
        2:       stall_mask = 8'h0F;
        default: stall_mask = 8'($urandom) | 8'h01;
      endcase
    end
    out_ready_i <= stall_mask[rcv_tick % 8];
    rcv_tick++;
  end

  // --------------------------------------------------------------------------
  // Scoreboard: everything is sampled at the rising edge. Predict on each
  // accepted sample beat, check each accepted result beat, and watch for a
  // stuck block.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    status_t want, got;
    if (rst_ni) begin
      if (cfg_we_i) store_setting(cfg_index_i, cfg_wdata_i);

      if (in_valid_i && in_ready_o) begin
        want = predict_held_status({accel_x_sample_i, accel_y_sample_i,
                                    accel_z_sample_i, gyro_x_sample_i,
                                    gyro_y_sample_i, gyro_z_sample_i});
        // a typed row overrides the prediction, the predictor still advances
        held_status_q.push_back(row_typed ? row_want : want);
      end

      if (out_valid_o && out_ready_i) begin
        got = {health_level_o, fault_kind_o, fault_value_o, debounce_level_o};
        if (held_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result beat: health %0d fault %0d value %0d level %0d",
                     got.health, got.fault, $signed(got.value), got.level);
        end else begin
          want = held_status_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $write("result mismatch: expected health %0d fault %0d value %0d level %0d,",
                     want.health, want.fault, $signed(want.value), want.level);
              $display(" got health %0d fault %0d value %0d level %0d",
                       got.health, got.fault, $signed(got.value), got.level);
            end
          end
        end
      end

      // watchdog: count cycles in which no beat moves on either channel
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Present one beat at the falling edge and hold it until accepted. Valid is
  // not dropped between back-to-back beats.
  task automatic send_sample(input sample_t s, input bit typed, input status_t want);
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    accel_x_sample_i <= s.ax;
    accel_y_sample_i <= s.ay;
    accel_z_sample_i <= s.az;
    gyro_x_sample_i  <= s.gx;
    gyro_y_sample_i  <= s.gy;
    gyro_z_sample_i  <= s.gz;
    row_typed         = typed;
    row_want          = want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid and idle the sender for a number of cycles
  task automatic pause_sender(input int cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Pick the settings of one phase: minimum, maximum, reset values, or a
  // random realistic set. The unused top bit above each 15-bit base is random.
  task automatic load_settings(input int phase);
    logic [15:0] ff, imp, hi, med, zo, ox, oy, oz;
    case (phase)
      0: begin
        ff = '0; imp = '0; hi = '0; med = '0;
        zo = mfdd_pkg::SAT_NEG; ox = mfdd_pkg::SAT_NEG;
        oy = mfdd_pkg::SAT_NEG; oz = mfdd_pkg::SAT_NEG;
      end
      4: begin
        ff = 16'hFFFF; imp = 16'hFFFF; hi = 16'hFFFF; med = 16'hFFFF;
        zo = mfdd_pkg::SAT_POS; ox = mfdd_pkg::SAT_POS;
        oy = mfdd_pkg::SAT_POS; oz = mfdd_pkg::SAT_POS;
      end
      PHASES - 1: begin
        ff = mfdd_pkg::FF_THR_RST; imp = mfdd_pkg::IMP_THR_RST;
        hi = {1'b0, mfdd_pkg::VIB_HIGH_RST}; med = {1'b0, mfdd_pkg::VIB_MED_RST};
        zo = '0; ox = '0; oy = '0; oz = '0;
      end
      default: begin
        ff  = 16'($urandom_range(0, 3000));
        imp = 16'($urandom_range(0, 6000));
        hi  = {1'($urandom), 15'($urandom_range(0, 1500))};
        med = {1'($urandom), 15'($urandom_range(0, 32'(hi[14:0])))};
        if ($urandom_range(0, 3) == 0) begin
          ff  = 16'($urandom);
          imp = 16'($urandom);
        end
        zo = $urandom_range(0, 1) ? clamp16(srand(800)) : 16'($urandom);
        ox = $urandom_range(0, 1) ? clamp16(srand(800)) : 16'($urandom);
        oy = $urandom_range(0, 1) ? clamp16(srand(800)) : 16'($urandom);
        oz = $urandom_range(0, 1) ? clamp16(srand(800)) : 16'($urandom);
      end
    endcase
    write_reg(mfdd_pkg::REG_FF_THR,   ff);
    write_reg(mfdd_pkg::REG_IMP_THR,  imp);
    write_reg(mfdd_pkg::REG_VIB_HIGH, hi);
    write_reg(mfdd_pkg::REG_VIB_MED,  med);
    write_reg(mfdd_pkg::REG_Z_OFF,    zo);
    write_reg(mfdd_pkg::REG_GOFF_X,   ox);
    write_reg(mfdd_pkg::REG_GOFF_Y,   oy);
    write_reg(mfdd_pkg::REG_GOFF_Z,   oz);
  endtask

  // Build a sample aimed at one class under the current settings. The aim is
  // loose; the predictor decides what the sample really is.
  function automatic sample_t make_sample(input kind_e kind);
    sample_t s;
    longint  ff, zo, span, dev;
    ff = longint'(cfg_ff_thr);
    zo = longint'(cfg_z_off);
    s  = {$urandom, $urandom, $urandom};
    case (kind)
      KIND_FREE_FALL: begin
        // each axis within half the threshold keeps the magnitude below it
        s.ax = clamp16(srand(ff / 2));
        s.ay = clamp16(srand(ff / 2));
        s.az = clamp16(srand(ff / 2));
      end
      KIND_IMPACT: begin
        dev  = longint'(cfg_imp_thr) + 1 + longint'($urandom_range(0, 3000));
        s.ax = clamp16(ff + longint'($urandom_range(0, 200)));
        s.ay = clamp16(srand(300));
        s.az = clamp16($urandom_range(0, 1) ? zo + dev : zo - dev);
      end
      KIND_STABLE, KIND_SHAKE: begin
        dev  = ff + longint'($urandom_range(0, 200));
        s.ax = clamp16($urandom_range(0, 1) ? dev : -dev);
        s.ay = clamp16(srand(300));
        s.az = clamp16(zo + srand(cfg_imp_thr < 1000 ? longint'(cfg_imp_thr) : 1000));
        // a stable sum stays below even the reduced warning threshold
        span = (kind == KIND_STABLE) ? longint'(cfg_vib_med) / 3
                                     : 2 * longint'(cfg_vib_high) + 50;
        s.gx = clamp16(longint'(cfg_goff_x) + srand(span));
        s.gy = clamp16(longint'(cfg_goff_y) + srand(span));
        s.gz = clamp16(longint'(cfg_goff_z) + srand(span));
      end
      default: ;  // noise: every field fully random
    endcase
    return s;
  endfunction

  function automatic kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return KIND_NOISE;
    if (r < 50) return KIND_STABLE;
    if (r < 65) return KIND_FREE_FALL;
    if (r < 80) return KIND_IMPACT;
    return KIND_SHAKE;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    kind_e kind;
    int    run, gap, burst_left, sent;

    // hold reset low, then release it away from the rising edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table under reset settings, back to back
    foreach (directed_rows[i])
      send_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);
    pause_sender(1);

    // random phases; settings change only with nothing in flight
    burst_left = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      while (held_status_q.size() != 0) @(posedge clk_i);
      load_settings(phase);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        // runs of one class let the counter climb to the limit and drain
        kind = pick_kind();
        run  = $urandom_range(1, 14);
        repeat (run) begin
          if (burst_left == 0) begin
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
            if (gap > 0) pause_sender(gap);
            burst_left = $urandom_range(1, 20);
          end
          send_sample(make_sample(kind), 1'b0, '0);
          burst_left--;
          sent++;
        end
      end
      pause_sender(1);
      burst_left = 0;
    end

    // drain, then give stray beats a chance to show up
    while (held_status_q.size() != 0) @(posedge clk_i);
    repeat (2 * SAMPLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
sv/mfdd_pkg.sv
sv/mfdd_accum.sv
sv/mfdd_isqrt.sv
sv/mfdd_classify.sv
sv/motion_fault_debounce_detector.sv
tb/sv/motion_fault_debounce_detector_test.sv
